[src/unicode_utf_transcoder_core_macros.svh]
`ifndef UNICODE_UTF_TRANSCODER_CORE_MACROS_SVH
`define UNICODE_UTF_TRANSCODER_CORE_MACROS_SVH

// Property holds in the same cycle, ignored while reset is asserted.
`define UTC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("transcoder assertion failed");

// Property holds in the following cycle, ignored while reset is asserted.
`define UTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("transcoder assertion failed");

// Property holds in the following cycle, checked during reset as well.
`define UTC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("transcoder assertion failed");

`endif

[src/utc_pkg.sv]
`default_nettype none

package utc_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int CP_W        = 21;

    localparam logic [2:0] ENC_UTF8    = 3'd0;
    localparam logic [2:0] ENC_UTF16LE = 3'd1;
    localparam logic [2:0] ENC_UTF16BE = 3'd2;
    localparam logic [2:0] ENC_UTF32LE = 3'd3;
    localparam logic [2:0] ENC_UTF32BE = 3'd4;

    localparam logic REG_SRC_ENC = 1'b0;
    localparam logic REG_DST_ENC = 1'b1;

    localparam logic [CP_W-1:0] REPL_CP   = 21'h00FFFD;
    localparam logic [CP_W-1:0] SUPP_BASE = 21'h010000;
    localparam logic [31:0]     MAX_CP    = 32'h0010FFFF;
    localparam logic [31:0]     SURR_LOW  = 32'h0000D800;
    localparam logic [31:0]     SURR_HIGH = 32'h0000DFFF;
    localparam logic [5:0]      HI_SURR_TAG = 6'b110110;
    localparam logic [5:0]      LO_SURR_TAG = 6'b110111;

    typedef logic [CP_W-1:0] t_cp;

    typedef struct packed {
        logic [2:0] src_enc;
        logic [2:0] dst_enc;
        logic       clear;
    } t_cfg;

    typedef struct packed {
        logic       cp0_valid;
        t_cp        cp0;
        logic       cp1_valid;
        t_cp        cp1;
        logic       tail_valid;
        logic [2:0] tail_count;
    } t_job;

    typedef struct packed {
        logic       valid;
        t_job       job;
    } t_push;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      len;
    } t_enc_out;

    function automatic t_cp check_cp(input logic [31:0] v);
        t_cp cp;
        if (v > MAX_CP || (v >= SURR_LOW && v <= SURR_HIGH)) begin
            cp = REPL_CP;
        end else begin
            cp = v[CP_W-1:0];
        end
        return cp;
    endfunction

    function automatic t_enc_out encode_cp(input t_cp cp, input logic [2:0] enc);
        t_enc_out   r;
        logic [CP_W-1:0] d;
        logic [15:0] hi;
        logic [15:0] lo;
        r  = '0;
        d  = cp - SUPP_BASE;
        hi = {HI_SURR_TAG, d[19:10]};
        lo = {LO_SURR_TAG, d[9:0]};
        case (enc) inside
            ENC_UTF8: begin
                if (cp <= 21'h00007F) begin
                    r.bytes[0] = cp[7:0];
                    r.len      = 3'd1;
                end else if (cp <= 21'h0007FF) begin
                    r.bytes[0] = {3'b110, cp[10:6]};
                    r.bytes[1] = {2'b10, cp[5:0]};
                    r.len      = 3'd2;
                end else if (cp <= 21'h00FFFF) begin
                    r.bytes[0] = {4'b1110, cp[15:12]};
                    r.bytes[1] = {2'b10, cp[11:6]};
                    r.bytes[2] = {2'b10, cp[5:0]};
                    r.len      = 3'd3;
                end else begin
                    r.bytes[0] = {5'b11110, cp[20:18]};
                    r.bytes[1] = {2'b10, cp[17:12]};
                    r.bytes[2] = {2'b10, cp[11:6]};
                    r.bytes[3] = {2'b10, cp[5:0]};
                    r.len      = 3'd4;
                end
            end
            ENC_UTF16LE, ENC_UTF16BE: begin
                if (cp > 21'h00FFFF) begin
                    if (enc == ENC_UTF16BE) begin
                        r.bytes = {lo[7:0], lo[15:8], hi[7:0], hi[15:8]};
                    end else begin
                        r.bytes = {lo[15:8], lo[7:0], hi[15:8], hi[7:0]};
                    end
                    r.len = 3'd4;
                end else begin
                    if (enc == ENC_UTF16BE) begin
                        r.bytes = {16'h0000, cp[7:0], cp[15:8]};
                    end else begin
                        r.bytes = {16'h0000, cp[15:8], cp[7:0]};
                    end
                    r.len = 3'd2;
                end
            end
            ENC_UTF32LE: begin
                r.bytes = {8'h00, 3'b000, cp[20:16], cp[15:8], cp[7:0]};
                r.len   = 3'd4;
            end
            ENC_UTF32BE: begin
                r.bytes = {cp[7:0], cp[15:8], 3'b000, cp[20:16], 8'h00};
                r.len   = 3'd4;
            end
            default: begin
                r.len = 3'd0;
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[src/utc_if.sv]
`default_nettype none

interface utc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] src_byte;
    logic       end_of_source;

    modport source (output valid, output src_byte, output end_of_source, input ready);
    modport sink (input valid, input src_byte, input end_of_source, output ready);
endinterface

interface utc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       kind;
    logic       last_of_run;

    modport source (output valid, output out_byte, output kind, output last_of_run, input ready);
    modport sink (input valid, input out_byte, input kind, input last_of_run, output ready);
endinterface

`default_nettype wire

[src/utc_cfg.sv]
`default_nettype none

module utc_cfg (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [utc_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [utc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [utc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                  pready,
    output utc_pkg::t_cfg                         o_cfg
);

    logic [2:0] r_src_enc;
    logic [2:0] r_dst_enc;
    logic       wr;

    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_enc <= utc_pkg::ENC_UTF8;
            r_dst_enc <= utc_pkg::ENC_UTF8;
        end else if (wr) begin
            unique case (paddr[2])
                utc_pkg::REG_SRC_ENC: r_src_enc <= pwdata[2:0];
                utc_pkg::REG_DST_ENC: r_dst_enc <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            utc_pkg::REG_SRC_ENC: prdata[2:0] = r_src_enc;
            utc_pkg::REG_DST_ENC: prdata[2:0] = r_dst_enc;
            default: ;
        endcase
    end

    assign o_cfg.src_enc = r_src_enc;
    assign o_cfg.dst_enc = r_dst_enc;
    assign o_cfg.clear   = wr;

endmodule

`default_nettype wire

[src/utc_front.sv]
`default_nettype none

module utc_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire utc_pkg::t_cfg i_cfg,
    utc_in_if.sink             i_src,
    input  wire logic          i_full,
    output utc_pkg::t_push     o_push
);

    logic [23:0]        r_buf;
    logic [2:0]         r_cnt;
    logic [1:0]         r_cont;
    utc_pkg::t_cp       r_acc;
    logic [9:0]         r_hs;
    logic               r_have;

    logic [23:0]        n_buf;
    logic [2:0]         n_cnt;
    logic [1:0]         n_cont;
    utc_pkg::t_cp       n_acc;
    logic [9:0]         n_hs;
    logic               n_have;

    logic               accept;
    logic               lead_go;
    logic               is16;
    logic               unit_done;
    logic               dest_ok;
    logic [7:0]         b;
    logic [2:0]         cnt_inc;
    logic [2:0]         tail_count;
    logic [31:0]        unit_word;
    logic [31:0]        unit_swap;
    logic [15:0]        unit16;
    utc_pkg::t_cp       acc_next;
    utc_pkg::t_cp       min_cp;
    utc_pkg::t_job      job;

    assign b           = i_src.src_byte;
    assign i_src.ready = !i_full;
    assign accept      = i_src.valid && !i_full;
    assign dest_ok     = i_cfg.dst_enc <= utc_pkg::ENC_UTF32BE;

    assign cnt_inc   = r_cnt + 3'd1;
    assign acc_next  = {r_acc[14:0], b[5:0]};
    assign unit_word = {8'h00, r_buf} | ({24'h000000, b} << {r_cnt[1:0], 3'b000});
    assign unit_swap = {unit_word[7:0], unit_word[15:8], unit_word[23:16], unit_word[31:24]};
    assign is16      = (i_cfg.src_enc == utc_pkg::ENC_UTF16LE) ||
                       (i_cfg.src_enc == utc_pkg::ENC_UTF16BE);
    assign unit_done = is16 ? (cnt_inc >= 3'd2) : (cnt_inc >= 3'd4);
    assign unit16    = (i_cfg.src_enc == utc_pkg::ENC_UTF16LE) ? unit_word[15:0]
                                                               : unit_swap[31:16];
    assign min_cp    = (cnt_inc == 3'd2) ? 21'h000080 :
                       (cnt_inc == 3'd3) ? 21'h000800 : utc_pkg::SUPP_BASE;

    always_comb begin
        n_buf   = r_buf;
        n_cnt   = r_cnt;
        n_cont  = r_cont;
        n_acc   = r_acc;
        n_hs    = r_hs;
        n_have  = r_have;
        lead_go = 1'b0;
        job     = '0;
        job.cp0 = utc_pkg::REPL_CP;
        job.cp1 = utc_pkg::REPL_CP;
        tail_count = '0;

        case (i_cfg.src_enc) inside
            utc_pkg::ENC_UTF8: begin
                if (r_cont != 2'd0) begin
                    if (b[7:6] == 2'b10) begin
                        n_acc  = acc_next;
                        n_cnt  = cnt_inc;
                        n_cont = r_cont - 2'd1;
                        if (r_cont == 2'd1) begin
                            job.cp0_valid = 1'b1;
                            job.cp0 = (acc_next < min_cp) ? utc_pkg::REPL_CP
                                    : utc_pkg::check_cp({11'h000, acc_next});
                            n_acc = '0;
                            n_cnt = '0;
                        end
                    end else begin
                        job.cp0_valid = 1'b1;
                        n_acc   = '0;
                        n_cont  = '0;
                        n_cnt   = '0;
                        lead_go = 1'b1;
                    end
                end else begin
                    lead_go = 1'b1;
                end
                if (lead_go) begin
                    if (b < 8'h80) begin
                        job.cp1_valid = 1'b1;
                        job.cp1 = {13'h0000, b};
                    end else if (b < 8'hC0 || b >= 8'hF8) begin
                        job.cp1_valid = 1'b1;
                    end else if (b < 8'hE0) begin
                        n_acc  = {16'h0000, b[4:0]};
                        n_cont = 2'd1;
                        n_cnt  = 3'd1;
                    end else if (b < 8'hF0) begin
                        n_acc  = {17'h00000, b[3:0]};
                        n_cont = 2'd2;
                        n_cnt  = 3'd1;
                    end else begin
                        n_acc  = {18'h00000, b[2:0]};
                        n_cont = 2'd3;
                        n_cnt  = 3'd1;
                    end
                end
            end
            utc_pkg::ENC_UTF16LE, utc_pkg::ENC_UTF16BE,
            utc_pkg::ENC_UTF32LE, utc_pkg::ENC_UTF32BE: begin
                if (!unit_done) begin
                    n_buf = unit_word[23:0];
                    n_cnt = cnt_inc;
                end else begin
                    n_buf = '0;
                    n_cnt = '0;
                    if (is16) begin
                        lead_go = 1'b1;
                        if (r_have) begin
                            n_have = 1'b0;
                            n_hs   = '0;
                            job.cp0_valid = 1'b1;
                            if (unit16[15:10] == utc_pkg::LO_SURR_TAG) begin
                                job.cp0 = utc_pkg::SUPP_BASE + {1'b0, r_hs, unit16[9:0]};
                                lead_go = 1'b0;
                            end
                        end
                        if (lead_go) begin
                            if (unit16[15:10] == utc_pkg::HI_SURR_TAG) begin
                                n_hs   = unit16[9:0];
                                n_have = 1'b1;
                            end else if (unit16[15:10] == utc_pkg::LO_SURR_TAG) begin
                                job.cp1_valid = 1'b1;
                            end else begin
                                job.cp1_valid = 1'b1;
                                job.cp1 = {5'h00, unit16};
                            end
                        end
                    end else begin
                        job.cp1_valid = 1'b1;
                        job.cp1 = utc_pkg::check_cp(
                            (i_cfg.src_enc == utc_pkg::ENC_UTF32LE) ? unit_word : unit_swap);
                    end
                end
            end
            default: ;
        endcase

        if (i_src.end_of_source) begin
            tail_count     = n_cnt + (n_have ? 3'd2 : 3'd0);
            job.tail_valid = tail_count != 3'd0;
            job.tail_count = tail_count;
            n_buf  = '0;
            n_cnt  = '0;
            n_cont = '0;
            n_acc  = '0;
            n_hs   = '0;
            n_have = 1'b0;
        end
    end

    assign o_push.valid = accept &&
                          (job.tail_valid || (dest_ok && (job.cp0_valid || job.cp1_valid)));
    assign o_push.job   = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg.clear) begin
            r_buf  <= '0;
            r_cnt  <= '0;
            r_cont <= '0;
            r_acc  <= '0;
            r_hs   <= '0;
            r_have <= 1'b0;
        end else if (accept) begin
            r_buf  <= n_buf;
            r_cnt  <= n_cnt;
            r_cont <= n_cont;
            r_acc  <= n_acc;
            r_hs   <= n_hs;
            r_have <= n_have;
        end
    end

endmodule

`default_nettype wire

[src/utc_queue.sv]
`default_nettype none

module utc_queue #(
    parameter int DEPTH = utc_pkg::QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire utc_pkg::t_push i_push,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_valid,
    output utc_pkg::t_job       o_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    utc_pkg::t_job      r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [CNT_W-1:0]   r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push.job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

[src/utc_back.sv]
`default_nettype none

module utc_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [2:0]    i_dst_enc,
    input  wire logic          i_valid,
    input  wire utc_pkg::t_job i_job,
    output logic               o_pop,
    utc_out_if.source          o_dst
);

    logic            r_busy;
    logic [3:0]      r_idx;
    logic [3:0]      r_last_idx;
    logic [3:0]      r_nbytes;
    logic [3:0][7:0] r_b0;
    logic [3:0][7:0] r_b1;
    logic [2:0]      r_len0;
    logic [2:0]      r_tail_count;

    utc_pkg::t_enc_out enc0;
    utc_pkg::t_enc_out enc1;
    logic [2:0]      len0;
    logic [2:0]      len1;
    logic [3:0]      sum;
    logic [3:0]      nbytes;
    logic [3:0]      rel;
    logic            last;
    logic            xfer;
    logic            load;

    assign enc0   = utc_pkg::encode_cp(i_job.cp0, i_dst_enc);
    assign enc1   = utc_pkg::encode_cp(i_job.cp1, i_dst_enc);
    assign len0   = i_job.cp0_valid ? enc0.len : 3'd0;
    assign len1   = i_job.cp1_valid ? enc1.len : 3'd0;
    assign sum    = {1'b0, len0} + {1'b0, len1};
    assign nbytes = (i_job.tail_valid && sum == 4'd8) ? 4'd7 : sum;

    assign last  = r_idx == r_last_idx;
    assign xfer  = r_busy && o_dst.ready;
    assign load  = i_valid && (!r_busy || (xfer && last));
    assign o_pop = load;

    assign rel = r_idx - {1'b0, r_len0};

    always_comb begin
        o_dst.valid       = r_busy;
        o_dst.last_of_run = last;
        o_dst.kind        = 1'b0;
        if (r_idx >= r_nbytes) begin
            o_dst.kind     = 1'b1;
            o_dst.out_byte = {5'b00000, r_tail_count};
        end else if (r_idx < {1'b0, r_len0}) begin
            o_dst.out_byte = r_b0[r_idx[1:0]];
        end else begin
            o_dst.out_byte = r_b1[rel[1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (xfer) begin
            if (last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_b0         <= enc0.bytes;
            r_b1         <= enc1.bytes;
            r_len0       <= len0;
            r_nbytes     <= nbytes;
            r_tail_count <= i_job.tail_count;
            r_last_idx   <= nbytes + {3'b000, i_job.tail_valid} - 4'd1;
        end
    end

endmodule

`default_nettype wire

[src/unicode_utf_transcoder_core.sv]
// Streaming transcoder between UTF-8, UTF-16LE/BE and UTF-32LE/BE. Source bytes enter one per
// cycle on i_src while the queue is not full; each completed code point leaves as 1 to 4
// destination bytes on o_dst, one byte per transfer, and a source byte marked end_of_source that
// strands a partial sequence adds one tail report (kind 1) carrying the stranded byte count.
// Invalid input is replaced by U+FFFD. The front end decodes a byte combinationally and hands
// its code points to a job queue of QUEUE_DEPTH entries; the back end encodes a job and drives
// one result per cycle while o_dst is ready, so a byte with several results holds the output
// until all are sent; input is sustained at one byte per cycle if each byte yields at most one
// result. Configuration registers sit at byte address 0 (source encoding) and 4 (destination
// encoding); writing either one discards any partial code point.
`default_nettype none

module unicode_utf_transcoder_core #(
    parameter int QUEUE_DEPTH = utc_pkg::QUEUE_DEPTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [utc_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [utc_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [utc_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    utc_in_if.sink                              i_src,
    utc_out_if.source                           o_dst
);

    utc_pkg::t_cfg  cfg;
    utc_pkg::t_push push;
    utc_pkg::t_job  head_job;
    logic           full;
    logic           head_valid;
    logic           pop;

    utc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    utc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_src   (i_src),
        .i_full  (full),
        .o_push  (push)
    );

    utc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_job   (head_job)
    );

    utc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_dst_enc (cfg.dst_enc),
        .i_valid   (head_valid),
        .i_job     (head_job),
        .o_pop     (pop),
        .o_dst     (o_dst)
    );

endmodule

`default_nettype wire

[src/utc_checker.sv]
`default_nettype none
`include "unicode_utf_transcoder_core_macros.svh"

module utc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_out_byte,
    input wire logic       i_out_kind,
    input wire logic       i_out_last
);

    // Nothing is pending and input is open right after reset.
    `UTC_ASSERT_NEXT_ALWAYS(a_reset_idle, i_clk, !i_rst_n, !i_out_valid && i_in_ready)

    // A tail report always closes the results of its input byte.
    `UTC_ASSERT_IMPLY(a_tail_last, i_clk, i_rst_n, i_out_valid && i_out_kind, i_out_last)

    // A stranded sequence holds one to three bytes, plus two for a pending high surrogate.
    `UTC_ASSERT_IMPLY(a_tail_count, i_clk, i_rst_n, i_out_valid && i_out_kind, i_out_byte != 8'd0 && i_out_byte <= 8'd5)

    // A stalled result keeps its payload until the transfer.
    `UTC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_byte) && $stable(i_out_kind) && $stable(i_out_last))

endmodule

bind unicode_utf_transcoder_core utc_checker u_utc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_src.ready),
    .i_out_valid (o_dst.valid),
    .i_out_ready (o_dst.ready),
    .i_out_byte  (o_dst.out_byte),
    .i_out_kind  (o_dst.kind),
    .i_out_last  (o_dst.last_of_run)
);

`default_nettype wire
